### rtl/core/pmy_pkg.sv
// ----------------------------------------------------------------------------
// pmy_pkg
// Shared types and constants of the premultiplied ARGB to YUVA converter.
// ----------------------------------------------------------------------------
package pmy_pkg;

  localparam int unsigned ChW           = 8;
  localparam int unsigned NumCh         = 3;
  localparam int unsigned DivW          = 2 * ChW;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned DivStages     = ChW / StepsPerStage;

  localparam int unsigned SumW  = 20;
  localparam int unsigned MagW  = SumW - 1;
  localparam int unsigned RecW  = 19;
  localparam int unsigned ProdW = MagW + RecW;

  // floor(x / 1000) = (x * ceil(2^28 / 1000)) >> 28 for the sum range used here
  localparam int unsigned DivShift = 28;
  localparam logic [RecW-1:0] DivRecip = RecW'(268436);
  localparam int unsigned QuoW = ProdW - DivShift;

  localparam logic signed [SumW-1:0] CoefYR = SumW'(257);
  localparam logic signed [SumW-1:0] CoefYG = SumW'(504);
  localparam logic signed [SumW-1:0] CoefYB = SumW'(98);
  localparam logic signed [SumW-1:0] CoefUR = -SumW'(148);
  localparam logic signed [SumW-1:0] CoefUG = -SumW'(291);
  localparam logic signed [SumW-1:0] CoefUB = SumW'(439);
  localparam logic signed [SumW-1:0] CoefVR = SumW'(439);
  localparam logic signed [SumW-1:0] CoefVG = -SumW'(368);
  localparam logic signed [SumW-1:0] CoefVB = -SumW'(71);
  localparam logic signed [SumW-1:0] LumaOffset   = SumW'(16000);
  localparam logic signed [SumW-1:0] ChromaOffset = SumW'(128000);

  localparam logic [ChW-1:0] NeutralLuma   = ChW'(16);
  localparam logic [ChW-1:0] NeutralChroma = ChW'(128);
  localparam logic [ChW-1:0] ChMax         = '1;

  // register stages from start to done_o
  localparam int unsigned PipeDepth = DivStages + 4;

  typedef struct packed {
    logic                       zero;
    logic [ChW-1:0]             alpha;
    logic [NumCh-1:0]           sat;
    logic [NumCh-1:0][DivW-1:0] work;
  } div_stage_t;

  typedef struct packed {
    logic                  zero;
    logic [ChW-1:0]        alpha;
    logic signed [SumW-1:0] y;
    logic signed [SumW-1:0] u;
    logic signed [SumW-1:0] v;
  } sum_stage_t;

  typedef struct packed {
    logic                        zero;
    logic [ChW-1:0]              alpha;
    logic [NumCh-1:0]            neg;
    logic [NumCh-1:0][ProdW-1:0] prod;
  } prod_stage_t;

endpackage

### rtl/core/premul_argb_to_yuva.sv
// ----------------------------------------------------------------------------
// premul_argb_to_yuva
// Premultiplied ARGB to BT.601 limited-range Y, Cb, Cr with alpha.
// ----------------------------------------------------------------------------
// Takes one pixel per clock: busy is never raised, so start may be held high
// every cycle. Each request gives exactly one result on done_o, in request
// order. The pipeline is the un-premultiply divider, four stages of two
// restoring steps each, followed by the matrix stage, the multiply-by-reciprocal
// stage for the divide by 1000 and the clamp into the output register. The
// receiver cannot stall: a result is shown for one cycle only.
module premul_argb_to_yuva
  import pmy_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [4*ChW-1:0]     argb_pixel_i,
  output logic                 done_o,
  output logic [ChW-1:0]       luma_o,
  output logic [ChW-1:0]       chroma_blue_o,
  output logic [ChW-1:0]       chroma_red_o,
  output logic [ChW-1:0]       alpha_out_o
);

  function automatic logic [DivW-1:0] div_step(input logic [DivW-1:0] w,
                                               input logic [ChW-1:0]  a);
    logic [ChW:0]    t;
    logic [ChW:0]    r;
    logic [DivW-1:0] res;
    t = {w[DivW-1:ChW], w[ChW-1]};
    if (t >= {1'b0, a}) begin
      r   = t - {1'b0, a};
      res = {r[ChW-1:0], w[ChW-2:0], 1'b1};
    end else begin
      res = {t[ChW-1:0], w[ChW-2:0], 1'b0};
    end
    return res;
  endfunction

  logic                 accept;
  logic [DivStages:0]   div_vld_q;
  logic [DivStages:0]   div_vld_d;
  div_stage_t           div_q [DivStages+1];
  div_stage_t           div_d [DivStages+1];
  logic                 sum_vld_q;
  sum_stage_t           sum_q;
  sum_stage_t           sum_d;
  logic                 prod_vld_q;
  prod_stage_t          prod_q;
  prod_stage_t          prod_d;
  logic                 out_vld_q;
  logic [ChW-1:0]       luma_q, cb_q, cr_q, alpha_q;
  logic [ChW-1:0]       luma_d, cb_d, cr_d, alpha_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // entry: scale each channel by 255 and add half alpha for rounding
  always_comb begin
    logic [ChW-1:0] a;
    logic [ChW-1:0] c;
    a = argb_pixel_i[4*ChW-1:3*ChW];
    div_d[0].zero  = (a == '0);
    div_d[0].alpha = a;
    for (int ch = 0; ch < NumCh; ch++) begin
      c = argb_pixel_i[(NumCh-ch)*ChW-1 -: ChW];
      div_d[0].sat[ch]  = (c > a);
      div_d[0].work[ch] = {c, {ChW{1'b0}}} - {{ChW{1'b0}}, c}
                          + {{(ChW+1){1'b0}}, a[ChW-1:1]};
    end
    for (int s = 1; s <= DivStages; s++) begin
      div_d[s] = div_q[s-1];
      for (int ch = 0; ch < NumCh; ch++) begin
        for (int k = 0; k < StepsPerStage; k++) begin
          div_d[s].work[ch] = div_step(div_d[s].work[ch], div_q[s-1].alpha);
        end
      end
    end
  end

  assign div_vld_d = {div_vld_q[DivStages-1:0], accept};

  // matrix
  always_comb begin
    logic signed [SumW-1:0] ch_s [NumCh];
    for (int ch = 0; ch < NumCh; ch++) begin
      ch_s[ch] = div_q[DivStages].sat[ch] ? SumW'(ChMax)
                 : SumW'(div_q[DivStages].work[ch][ChW-1:0]);
    end
    sum_d.zero  = div_q[DivStages].zero;
    sum_d.alpha = div_q[DivStages].alpha;
    sum_d.y = CoefYR * ch_s[0] + CoefYG * ch_s[1] + CoefYB * ch_s[2] + LumaOffset;
    sum_d.u = CoefUR * ch_s[0] + CoefUG * ch_s[1] + CoefUB * ch_s[2] + ChromaOffset;
    sum_d.v = CoefVR * ch_s[0] + CoefVG * ch_s[1] + CoefVB * ch_s[2] + ChromaOffset;
  end

  // divide by 1000: multiply by reciprocal
  always_comb begin
    logic signed [SumW-1:0] s [NumCh];
    s[0] = sum_q.y;
    s[1] = sum_q.u;
    s[2] = sum_q.v;
    prod_d.zero  = sum_q.zero;
    prod_d.alpha = sum_q.alpha;
    for (int ch = 0; ch < NumCh; ch++) begin
      prod_d.neg[ch]  = s[ch][SumW-1];
      prod_d.prod[ch] = ProdW'(s[ch][MagW-1:0]) * ProdW'(DivRecip);
    end
  end

  // clamp and select neutral black for zero alpha
  always_comb begin
    logic [QuoW-1:0] qv;
    logic [ChW-1:0]  res [NumCh];
    for (int ch = 0; ch < NumCh; ch++) begin
      qv = prod_q.prod[ch][ProdW-1:DivShift];
      if (prod_q.neg[ch]) begin
        res[ch] = '0;
      end else if (qv > QuoW'(ChMax)) begin
        res[ch] = ChMax;
      end else begin
        res[ch] = qv[ChW-1:0];
      end
    end
    if (prod_q.zero) begin
      luma_d = NeutralLuma;
      cb_d   = NeutralChroma;
      cr_d   = NeutralChroma;
    end else begin
      luma_d = res[0];
      cb_d   = res[1];
      cr_d   = res[2];
    end
    alpha_d = prod_q.alpha;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_vld_q  <= '0;
      sum_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      div_vld_q  <= div_vld_d;
      sum_vld_q  <= div_vld_q[DivStages];
      prod_vld_q <= sum_vld_q;
      out_vld_q  <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s <= DivStages; s++) begin
      if (div_vld_d[s]) begin
        div_q[s] <= div_d[s];
      end
    end
    if (div_vld_q[DivStages]) begin
      sum_q <= sum_d;
    end
    if (sum_vld_q) begin
      prod_q <= prod_d;
    end
    if (prod_vld_q) begin
      luma_q  <= luma_d;
      cb_q    <= cb_d;
      cr_q    <= cr_d;
      alpha_q <= alpha_d;
    end
  end

  assign done_o        = out_vld_q;
  assign luma_o        = luma_q;
  assign chroma_blue_o = cb_q;
  assign chroma_red_o  = cr_q;
  assign alpha_out_o   = alpha_q;

endmodule

### rtl/core/pmy_checker.sv
// ----------------------------------------------------------------------------
// pmy_checker
// Port-level checks of the premultiplied ARGB to YUVA converter.
// ----------------------------------------------------------------------------
module pmy_checker
  import pmy_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic [4*ChW-1:0] argb_pixel_i,
  input logic             done_o,
  input logic [ChW-1:0]   luma_o,
  input logic [ChW-1:0]   chroma_blue_o,
  input logic [ChW-1:0]   chroma_red_o,
  input logic [ChW-1:0]   alpha_out_o
);

  logic [PipeDepth-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= {acc_q[PipeDepth-2:0], start && !busy};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == acc_q[PipeDepth-1])
    else $error("result count or timing does not match requests");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> alpha_out_o == $past(argb_pixel_i[4*ChW-1:3*ChW], PipeDepth))
    else $error("alpha not passed through");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && alpha_out_o == '0 |->
      luma_o == NeutralLuma && chroma_blue_o == NeutralChroma &&
      chroma_red_o == NeutralChroma)
    else $error("zero alpha did not give neutral black");

endmodule

bind premul_argb_to_yuva pmy_checker u_pmy_checker (.*);

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for premul_argb_to_yuva. ARGB requests, mostly
// premultiplied, go in through the start/busy port. Every Y, Cb, Cr, A result
// on done_o is compared with a local integer model of the un-premultiply divide
// and the BT.601 limited-range matrix.
// ----------------------------------------------------------------------------
module testbench;
  import pmy_pkg::*;

  localparam int unsigned HalfPeriod   = 4;
  localparam int unsigned ResetCycles  = 4;
  localparam int unsigned SettleCycles = PipeDepth + 4;
  localparam int unsigned RunLimit     = 2_000_000;
  localparam int unsigned MaxReported  = 10;
  localparam int unsigned DrainEvery   = 250;

  localparam logic [ChW-1:0] BlackLuma   = 8'd16;
  localparam logic [ChW-1:0] BlackChroma = 8'd128;

  typedef struct packed {
    logic [ChW-1:0] luma;
    logic [ChW-1:0] cb;
    logic [ChW-1:0] cr;
    logic [ChW-1:0] alpha;
  } yuva_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               start        = 1'b0;
  logic [4*ChW-1:0]   argb_pixel_i = '0;
  logic               busy;
  logic               done_o;
  logic [ChW-1:0]     luma_o;
  logic [ChW-1:0]     chroma_blue_o;
  logic [ChW-1:0]     chroma_red_o;
  logic [ChW-1:0]     alpha_out_o;

  yuva_t       yuva_expected_q[$];
  int unsigned mismatch_count = 0;
  bit          gaps_on        = 1'b1;

  premul_argb_to_yuva dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .argb_pixel_i  (argb_pixel_i),
    .done_o        (done_o),
    .luma_o        (luma_o),
    .chroma_blue_o (chroma_blue_o),
    .chroma_red_o  (chroma_red_o),
    .alpha_out_o   (alpha_out_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  function automatic logic [ChW-1:0] clamp_u8(input int v);
    if (v < 0) return '0;
    if (v > 255) return 8'd255;
    return v[ChW-1:0];
  endfunction

  // saturate the quotient for colour above alpha
  function automatic int unpremultiply_ch(input int c, input int a);
    int q;
    q = (c * 255 + a / 2) / a;
    return (q > 255) ? 255 : q;
  endfunction

  function automatic yuva_t convert_pixel(input logic [4*ChW-1:0] px);
    yuva_t res;
    int    a;
    int    r;
    int    g;
    int    b;
    a = px[31:24];
    if (a == 0) begin
      res.luma  = BlackLuma;
      res.cb    = BlackChroma;
      res.cr    = BlackChroma;
      res.alpha = '0;
      return res;
    end
    r = unpremultiply_ch(px[23:16], a);
    g = unpremultiply_ch(px[15:8], a);
    b = unpremultiply_ch(px[7:0], a);
    res.luma  = clamp_u8((257 * r + 504 * g + 98 * b + 16000) / 1000);
    res.cb    = clamp_u8((-148 * r - 291 * g + 439 * b + 128000) / 1000);
    res.cr    = clamp_u8((439 * r - 368 * g - 71 * b + 128000) / 1000);
    res.alpha = px[31:24];
    return res;
  endfunction

  function automatic logic [4*ChW-1:0] random_premultiplied();
    logic [ChW-1:0] a;
    case ($urandom_range(0, 9))
      0: a = 8'hFF;
      1: a = 8'($urandom_range(1, 3));
      default: a = 8'($urandom_range(1, 255));
    endcase
    return {a, 8'($urandom_range(0, a)), 8'($urandom_range(0, a)),
            8'($urandom_range(0, a))};
  endfunction

  // call at a falling edge; returns at a falling edge with start still high
  task automatic send_pixel(input logic [4*ChW-1:0] px);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      start        <= 1'b0;
      argb_pixel_i <= $urandom;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    start        <= 1'b1;
    argb_pixel_i <= px;
    do @(posedge clk_i); while (busy !== 1'b0);
    yuva_expected_q = {yuva_expected_q, convert_pixel(px)};
    @(negedge clk_i);
  endtask

  task automatic await_drain();
    start <= 1'b0;
    do @(negedge clk_i); while (yuva_expected_q.size() != 0);
  endtask

  task automatic note_mismatch(input bit orphan, input yuva_t want, input yuva_t got);
    mismatch_count++;
    if (mismatch_count <= MaxReported) begin
      if (orphan)
        $display("%0t: result with no request outstanding: Y %0d U %0d V %0d A %0d",
                 $time, got.luma, got.cb, got.cr, got.alpha);
      else
        $display("%0t: expected Y %0d U %0d V %0d A %0d, got Y %0d U %0d V %0d A %0d",
                 $time, want.luma, want.cb, want.cr, want.alpha,
                 got.luma, got.cb, got.cr, got.alpha);
    end
  endtask

  always @(posedge clk_i) begin
    yuva_t want;
    yuva_t got;
    if (rst_ni && done_o) begin
      got = '{luma_o, chroma_blue_o, chroma_red_o, alpha_out_o};
      if (yuva_expected_q.size() == 0) begin
        note_mismatch(1'b1, got, got);
      end else begin
        want = yuva_expected_q.pop_front();
        if (got.luma !== want.luma || got.cb !== want.cb ||
            got.cr !== want.cr || got.alpha !== want.alpha)
          note_mismatch(1'b0, want, got);
      end
    end
  end

  task automatic test_alpha_zero();
    logic [4*ChW-1:0] pixels [4] = '{32'h0000_0000, 32'h00FF_FFFF, 32'h0012_3456,
                                      32'h0080_0080};
    foreach (pixels[i]) send_pixel(pixels[i]);
  endtask

  task automatic test_opaque_extremes();
    logic [4*ChW-1:0] pixels [8] = '{32'hFF00_0000, 32'hFFFF_FFFF, 32'hFFFF_0000,
                                      32'hFF00_FF00, 32'hFF00_00FF, 32'hFFFF_FF00,
                                      32'hFF00_FFFF, 32'hFFFF_00FF};
    foreach (pixels[i]) send_pixel(pixels[i]);
  endtask

  task automatic test_partial_alpha();
    logic [4*ChW-1:0] pixels [5] = '{32'h0101_0101, 32'h8040_4040, 32'h7F7F_7F7F,
                                      32'h8080_8080, 32'h0201_0001};
    foreach (pixels[i]) send_pixel(pixels[i]);
  endtask

  task automatic test_colour_above_alpha();
    logic [4*ChW-1:0] pixels [4] = '{32'h01FF_FFFF, 32'h10FF_2000, 32'h7FFF_80FE,
                                      32'h80FF_0081};
    foreach (pixels[i]) send_pixel(pixels[i]);
  endtask

  task automatic test_premultiplied_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_pixel(random_premultiplied());
      if (i % DrainEvery == DrainEvery - 1) await_drain();
    end
  endtask

  task automatic test_raw_random(input int unsigned count);
    logic [4*ChW-1:0] px;
    for (int unsigned i = 0; i < count; i++) begin
      px = $urandom;
      if ($urandom_range(0, 15) == 0) px[31:24] = '0;
      send_pixel(px);
    end
  endtask

  task automatic test_full_rate(input int unsigned count);
    gaps_on = 1'b0;
    for (int unsigned i = 0; i < count; i++) send_pixel(random_premultiplied());
  endtask

  initial begin
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_alpha_zero();
    test_opaque_extremes();
    test_partial_alpha();
    test_colour_above_alpha();
    await_drain();
    test_premultiplied_random(1000);
    test_raw_random(450);
    test_full_rate(300);
    await_drain();
    repeat (SettleCycles) @(negedge clk_i);
    if (mismatch_count == 0 && yuva_expected_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #(RunLimit);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
